// File: sv/mphb_pkg.sv
// Package for the peak-hold meter ballistics block.
// Shared types, register codes, reset values and saturating helpers; no dependencies.
package mphb_pkg;

  localparam int LEVEL_W     = 16;
  localparam int AGE_W       = 16;
  localparam int RATE_W      = 16;
  localparam int ELAPSED_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int MAX_BARS    = 2;
  localparam int CHANNELS_DEFAULT = 2;

  localparam logic [15:0] MAX_ELAPSED_MS  = 16'd250;
  localparam logic [15:0] PEAK_FULL_SCALE = 16'd16384;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [AGE_W-1:0]          age_t;
  typedef logic [RATE_W-1:0]         rate_t;
  typedef logic [ELAPSED_W-1:0]      elapsed_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FLOOR_LEVEL     = 3'd0,
    REG_SILENT_LEVEL    = 3'd1,
    REG_STALL_FALL_RATE = 3'd2,
    REG_HOLD_TIME_MS    = 3'd3,
    REG_HOLD_FALL_RATE  = 3'd4,
    REG_OVER_TIME_MS    = 3'd5
  } reg_index_t;

  localparam level_t RESET_FLOOR_LEVEL     = -16'sd15360;
  localparam level_t RESET_SILENT_LEVEL    = 16'sh8000;
  localparam rate_t  RESET_STALL_FALL_RATE = 16'd9830;
  localparam age_t   RESET_HOLD_TIME_MS    = 16'd2000;
  localparam rate_t  RESET_HOLD_FALL_RATE  = 16'd1311;
  localparam age_t   RESET_OVER_TIME_MS    = 16'd1500;

  typedef struct packed {
    level_t floor_level;
    level_t silent_level;
    rate_t  stall_fall_rate;
    age_t   hold_time_ms;
    rate_t  hold_fall_rate;
    age_t   over_time_ms;
  } cfg_t;

  // per-request control shared by every lane
  typedef struct packed {
    logic     stalled;
    elapsed_t elapsed;
    rate_t    stall_fall;
    rate_t    hold_fall;
  } step_t;

  function automatic level_t sat_sub(input level_t a, input rate_t amount);
    logic signed [LEVEL_W+1:0] r;
    r = {{2{a[LEVEL_W-1]}}, a} - $signed({2'b00, amount});
    if (r < $signed({{3{1'b1}}, {(LEVEL_W-1){1'b0}}})) begin
      sat_sub = {1'b1, {(LEVEL_W-1){1'b0}}};
    end else begin
      sat_sub = r[LEVEL_W-1:0];
    end
  endfunction

  function automatic age_t age_add(input age_t age, input elapsed_t ms);
    logic [AGE_W:0] r;
    r = {1'b0, age} + {{(AGE_W+1-ELAPSED_W){1'b0}}, ms};
    if (r[AGE_W]) begin
      age_add = {AGE_W{1'b1}};
    end else begin
      age_add = r[AGE_W-1:0];
    end
  endfunction

  // fall = (rate * elapsed) >> 8
  function automatic rate_t fall_amount(input rate_t rate, input elapsed_t ms);
    logic [RATE_W+ELAPSED_W-1:0] p;
    p = rate * ms;
    fall_amount = p[RATE_W+ELAPSED_W-1:ELAPSED_W];
  endfunction

endpackage

// File: sv/mphb_cfg.sv
// Configuration register file of the meter ballistics block.
// Depends on mphb_pkg for register codes, reset values and cfg_t.
module mphb_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mphb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mphb_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mphb_pkg::cfg_t                  cfg
);
  import mphb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_level     <= RESET_FLOOR_LEVEL;
      cfg.silent_level    <= RESET_SILENT_LEVEL;
      cfg.stall_fall_rate <= RESET_STALL_FALL_RATE;
      cfg.hold_time_ms    <= RESET_HOLD_TIME_MS;
      cfg.hold_fall_rate  <= RESET_HOLD_FALL_RATE;
      cfg.over_time_ms    <= RESET_OVER_TIME_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOOR_LEVEL:     cfg.floor_level     <= $signed(cfg_data);
        REG_SILENT_LEVEL:    cfg.silent_level    <= $signed(cfg_data);
        REG_STALL_FALL_RATE: cfg.stall_fall_rate <= cfg_data;
        REG_HOLD_TIME_MS:    cfg.hold_time_ms    <= cfg_data;
        REG_HOLD_FALL_RATE:  cfg.hold_fall_rate  <= cfg_data;
        REG_OVER_TIME_MS:    cfg.over_time_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/mphb_lane.sv
// One channel of meter ballistics: shown level, hold marker and over flag state.
// Depends on mphb_pkg for types, cfg_t, step_t and saturating helpers.
module mphb_lane (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  mphb_pkg::cfg_t       cfg,
  input  mphb_pkg::step_t      step,
  input  mphb_pkg::level_t     momentary,
  input  logic [15:0]          peak,
  output mphb_pkg::level_t     level_next,
  output mphb_pkg::level_t     hold_next,
  output logic                 over_next
);
  import mphb_pkg::*;

  level_t shown_level;
  level_t hold_level;
  age_t   hold_age;
  logic   over_flag;
  age_t   over_age;

  age_t   hold_age_next;
  age_t   over_age_next;
  age_t   hold_age_inc;
  age_t   over_age_inc;
  level_t hold_fallen;

  always_comb begin
    if (step.stalled) begin
      level_next = (shown_level > cfg.floor_level)
        ? sat_sub(shown_level, step.stall_fall) : cfg.silent_level;
    end else begin
      level_next = momentary;
    end

    hold_age_inc = age_add(hold_age, step.elapsed);
    hold_fallen  = sat_sub(hold_level, step.hold_fall);
    if (level_next >= hold_level) begin
      hold_next     = level_next;
      hold_age_next = '0;
    end else begin
      hold_age_next = hold_age_inc;
      if (hold_age_inc > cfg.hold_time_ms) begin
        hold_next = (hold_fallen > level_next) ? hold_fallen : level_next;
      end else begin
        hold_next = hold_level;
      end
    end

    over_age_inc  = age_add(over_age, step.elapsed);
    over_next     = over_flag;
    over_age_next = over_age;
    if (peak >= PEAK_FULL_SCALE) begin
      over_next     = 1'b1;
      over_age_next = '0;
    end else if (over_flag) begin
      over_age_next = over_age_inc;
      if (over_age_inc > cfg.over_time_ms) begin
        over_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_level <= RESET_SILENT_LEVEL;
      hold_level  <= RESET_SILENT_LEVEL;
      hold_age    <= '0;
      over_flag   <= 1'b0;
      over_age    <= '0;
    end else if (advance) begin
      shown_level <= level_next;
      hold_level  <= hold_next;
      hold_age    <= hold_age_next;
      over_flag   <= over_next;
      over_age    <= over_age_next;
    end
  end

endmodule

// File: sv/meter_peak_hold_ballistics.sv
// Level meter with peak-hold marker and latched over flag, two channel bars.
// The input register takes the request; the result register takes the per-lane
// update when advance is high, that is when the output is not stalled.
// Throughput: one request per cycle unless stalled; set by the per-lane update.
// Reset: synchronous rst, no clearing pass; clears in_full and out_valid, sets levels
// and holds to silent, ages, flags and last block count to zero; data is not reset.
module meter_peak_hold_ballistics #(
  parameter int CHANNELS = mphb_pkg::CHANNELS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mphb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mphb_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      elapsed_ms,
  input  logic [31:0]                      block_count,
  input  logic [7:0]                       channel_count,
  input  logic signed [15:0]               momentary_left,
  input  logic signed [15:0]               momentary_right,
  input  logic [15:0]                      peak_left,
  input  logic [15:0]                      peak_right,
  input  logic signed [15:0]               programme_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       bars_shown,
  output logic signed [15:0]               level_left,
  output logic signed [15:0]               level_right,
  output logic signed [15:0]               hold_left,
  output logic signed [15:0]               hold_right,
  output logic                             over_left,
  output logic                             over_right,
  output logic signed [15:0]               programme_out
);
  import mphb_pkg::*;

  localparam int LANES = (CHANNELS < MAX_BARS) ? CHANNELS : MAX_BARS;

  cfg_t cfg;

  logic        in_full;
  elapsed_t    in_elapsed;
  logic [31:0] in_blocks;
  logic        in_mono;
  level_t      in_mom   [MAX_BARS];
  logic [15:0] in_peak  [MAX_BARS];
  level_t      in_prog;

  logic [31:0] last_block_count;
  logic        advance;
  step_t       step;

  level_t lane_level [MAX_BARS];
  level_t lane_hold  [MAX_BARS];
  logic   lane_over  [MAX_BARS];
  level_t prog_next;

  mphb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_elapsed <= (elapsed_ms > MAX_ELAPSED_MS) ? MAX_ELAPSED_MS[ELAPSED_W-1:0]
                                                  : elapsed_ms[ELAPSED_W-1:0];
      in_blocks  <= block_count;
      in_mono    <= (channel_count == 8'd1);
      in_mom[0]  <= momentary_left;
      in_mom[1]  <= momentary_right;
      in_peak[0] <= peak_left;
      in_peak[1] <= peak_right;
      in_prog    <= programme_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_block_count <= '0;
    end else if (advance) begin
      last_block_count <= in_blocks;
    end
  end

  always_comb begin
    step.stalled    = (in_blocks == last_block_count);
    step.elapsed    = in_elapsed;
    step.stall_fall = fall_amount(cfg.stall_fall_rate, in_elapsed);
    step.hold_fall  = fall_amount(cfg.hold_fall_rate, in_elapsed);
  end

  for (genvar i = 0; i < MAX_BARS; i++) begin : g_lane
    if (i < LANES) begin : g_on
      mphb_lane u_lane (
        .clk        (clk),
        .rst        (rst),
        .advance    (advance),
        .cfg        (cfg),
        .step       (step),
        .momentary  (in_mom[i]),
        .peak       (in_peak[i]),
        .level_next (lane_level[i]),
        .hold_next  (lane_hold[i]),
        .over_next  (lane_over[i])
      );
    end else begin : g_off
      assign lane_level[i] = cfg.silent_level;
      assign lane_hold[i]  = cfg.silent_level;
      assign lane_over[i]  = 1'b0;
    end
  end

  always_comb begin
    if (!step.stalled) begin
      prog_next = in_prog;
    end else if (LANES > 1 && !in_mono && lane_level[1] > lane_level[0]) begin
      prog_next = lane_level[1];
    end else begin
      prog_next = lane_level[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bars_shown    <= in_mono ? 2'd1 : 2'd2;
      level_left    <= lane_level[0];
      level_right   <= lane_level[1];
      hold_left     <= lane_hold[0];
      hold_right    <= lane_hold[1];
      over_left     <= lane_over[0];
      over_right    <= lane_over[1];
      programme_out <= prog_next;
    end
  end

endmodule
